@@ design/stereo_multitap_echo_assert.svh @@
// Assertion macros shared by the echo block.
`ifndef STEREO_MULTITAP_ECHO_ASSERT_SVH
`define STEREO_MULTITAP_ECHO_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SME_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SME_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/sme_pkg.sv @@
package sme_pkg;

  // Sample and gain formats
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;
  localparam logic [GAIN_W-1:0] Q_ONE    = 16'd32768;
  localparam logic [31:0]       Q_ROUND  = 32'd16384;

  // Defaults for the top-level parameters
  localparam int DELAY_DEPTH_DEF = 262144;
  localparam int MAX_TAPS_DEF    = 5;

  // Configuration registers
  localparam int CFG_DATA_W = 16;
  typedef enum logic [1:0] {
    CFG_TAP_SPACING = 2'd0,
    CFG_ECHO_GAIN   = 2'd1,
    CFG_TAP_COUNT   = 2'd2
  } cfg_index_t;

  localparam logic [15:0] TAP_SPACING_RST = 16'd44100;
  localparam logic [15:0] ECHO_GAIN_RST   = 16'd16384;
  localparam logic [2:0]  TAP_COUNT_RST   = 3'd3;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TAPS,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Control shared by both channel lanes
  typedef struct packed {
    logic              load;
    logic              add;
    logic [GAIN_W-1:0] gain;
  } lane_ctrl_t;

endpackage

@@ design/stereo_multitap_echo.sv @@
// Channel   | Dir | Fields                              | Handshake
// s_*       | in  | tdata: left_in, right_in; tuser: bypass | tvalid/tready
// m_*       | out | tdata: left_out, right_out           | tvalid/tready
// cfg_*     | in  | cfg_index selects, cfg_data value     | cfg_we, no wait
//
// An item occupies the sequencer in these steps, in order: accept, N tap reads,
// drain, result load, N being tap_count clamped to MAX_TAPS, one tap read per cycle
// from the single read port. A bypass item goes from accept straight to result load.
// Reset is synchronous; it zeroes the fill count and write pointer, the delay
// memory itself is not cleared. A waiting result does not block acceptance of the
// next item; that item holds in its last step until the result is taken.
`include "stereo_multitap_echo_assert.svh"

module stereo_multitap_echo
  import sme_pkg::*;
#(
  parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
  parameter int MAX_TAPS    = MAX_TAPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [31:0]           s_tdata,   // [15:0] left_in, [31:16] right_in
  input  logic                  s_tuser,   // [0] bypass
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [31:0]           m_tdata,   // [15:0] left_out, [31:16] right_out
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW     = $clog2(DELAY_DEPTH);
  localparam int FW     = $clog2(DELAY_DEPTH + 1);
  localparam int TW     = $clog2(MAX_TAPS + 1);
  localparam int BACK_W = 17 + $clog2(MAX_TAPS + 1);
  localparam int CW     = ((BACK_W > FW) ? BACK_W : FW) + 1;

  // Configuration registers
  logic [15:0] tap_spacing;
  logic [15:0] echo_gain;
  logic [2:0]  tap_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_spacing <= TAP_SPACING_RST;
      echo_gain   <= ECHO_GAIN_RST;
      tap_count   <= TAP_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TAP_SPACING: tap_spacing <= cfg_data;
        CFG_ECHO_GAIN:   echo_gain   <= cfg_data;
        CFG_TAP_COUNT:   tap_count   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Clamped settings
  logic [GAIN_W-1:0] gain_clamped;
  logic [TW-1:0]     taps_clamped;

  always_comb begin
    gain_clamped = (echo_gain > Q_ONE) ? Q_ONE : echo_gain;
    taps_clamped = (32'(tap_count) > MAX_TAPS) ? TW'(MAX_TAPS) : TW'(tap_count);
  end

  // Sequencer and history state
  state_t            state;
  state_t            state_next;
  logic [AW-1:0]     wp;
  logic [FW-1:0]     fill_count;
  logic [TW-1:0]     rem;
  logic [BACK_W-1:0] back;
  logic [GAIN_W-1:0] g;
  logic [GAIN_W-1:0] g_next;
  logic              rd_valid;
  logic [GAIN_W-1:0] rd_gain;
  logic [31:0]       pair;
  logic              out_valid;
  logic [31:0]       out_data;

  logic              accept;
  logic              hit;
  logic              ram_re;
  logic              ram_we;
  logic              finish_go;
  logic [CW-1:0]     diff;
  logic [CW-1:0]     addr_wide;
  logic [AW-1:0]     raddr;
  logic [31:0]       rdata;
  logic [31:0]       gain_prod;

  assign accept = s_tvalid && s_tready;

  // Tap gate and read address: wp - back, wrapped
  always_comb begin
    hit  = CW'(fill_count) > CW'(back);
    diff = CW'(wp) - CW'(back);
    if (diff[CW-1]) begin
      addr_wide = diff + CW'(DELAY_DEPTH);
    end else begin
      addr_wide = diff;
    end
    raddr = addr_wide[AW-1:0];
  end

  // Next tap gain, Q1.15 round half up
  always_comb begin
    gain_prod = 32'(g) * 32'(gain_clamped) + Q_ROUND;
    g_next    = gain_prod[30:15];
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (s_tuser) begin
            state_next = ST_FINISH;
          end else if (taps_clamped != '0) begin
            state_next = ST_TAPS;
          end else begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_TAPS: begin
        if (rem == TW'(1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_next = ST_FINISH;
      ST_FINISH: begin
        if (finish_go) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_tready  = (state == ST_IDLE);
    ram_re    = (state == ST_TAPS) && hit;
    ram_we    = (state == ST_DRAIN);
    finish_go = (state == ST_FINISH) && (!out_valid || m_tready);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      wp         <= '0;
      fill_count <= '0;
      rd_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= ram_re;
      if (accept && s_tuser) begin
        fill_count <= '0;
      end else if (ram_we) begin
        wp <= (wp == AW'(DELAY_DEPTH - 1)) ? '0 : wp + AW'(1);
        if (fill_count != FW'(DELAY_DEPTH)) begin
          fill_count <= fill_count + FW'(1);
        end
      end
      if (finish_go) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Tap walk: distance, gain and count advance once per tap
  always_ff @(posedge clk) begin
    if (accept) begin
      pair <= s_tdata;
      rem  <= taps_clamped;
      back <= BACK_W'(1);
      g    <= Q_ONE;
    end else if (state == ST_TAPS) begin
      rem  <= rem - TW'(1);
      back <= back + BACK_W'(tap_spacing);
      g    <= g_next;
    end
    rd_gain <= g;
  end

  // Delay memory: left in the low half, right in the high half
  sme_ram #(
    .WIDTH(32),
    .DEPTH(DELAY_DEPTH)
  ) u_history (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wp),
    .wdata(pair),
    .re   (ram_re),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Channel lanes
  lane_ctrl_t                 lane_ctrl;
  logic signed [SAMPLE_W-1:0] left_res;
  logic signed [SAMPLE_W-1:0] right_res;

  assign lane_ctrl = '{load: accept, add: rd_valid, gain: rd_gain};

  sme_lane #(.MAX_TAPS(MAX_TAPS)) u_lane_left (
    .clk   (clk),
    .ctrl  (lane_ctrl),
    .dry   (s_tdata[15:0]),
    .echo  (rdata[15:0]),
    .result(left_res)
  );

  sme_lane #(.MAX_TAPS(MAX_TAPS)) u_lane_right (
    .clk   (clk),
    .ctrl  (lane_ctrl),
    .dry   (s_tdata[31:16]),
    .echo  (rdata[31:16]),
    .result(right_res)
  );

  // Merge both lanes into the result register
  always_ff @(posedge clk) begin
    if (finish_go) begin
      out_data <= {right_res, left_res};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // Checks
  `SME_ASSERT_NOW(a_fill_bound, 1'b1, fill_count <= FW'(DELAY_DEPTH), "fill count above depth")
  `SME_ASSERT_NOW(a_read_in_taps, ram_re, state == ST_TAPS, "delay read outside tap walk")
  `SME_ASSERT_NEXT(a_bypass_clears, accept && s_tuser, fill_count == '0, "bypass left history")
  `SME_ASSERT_NOW(a_load_from_finish, $rose(m_tvalid), $past(state) == ST_FINISH, "result without finish")

endmodule

@@ design/sme_ram.sv @@
module sme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/sme_lane.sv @@
module sme_lane
  import sme_pkg::*;
#(
  parameter int MAX_TAPS = MAX_TAPS_DEF
) (
  input  logic                       clk,
  input  lane_ctrl_t                 ctrl,
  input  logic signed [SAMPLE_W-1:0] dry,
  input  logic signed [SAMPLE_W-1:0] echo,
  output logic signed [SAMPLE_W-1:0] result
);

  // Dry sample plus MAX_TAPS echoes of at most 2^15 each
  localparam int ACC_W = 17 + $clog2(MAX_TAPS + 1);

  logic signed [ACC_W-1:0] acc;
  logic signed [32:0]      prod;
  logic signed [32:0]      rounded;
  logic signed [17:0]      scaled;

  // Q1.15 scale, round half up
  always_comb begin
    prod    = $signed({{17{echo[SAMPLE_W-1]}}, echo}) * $signed({17'b0, ctrl.gain});
    rounded = prod + 33'sd16384;
    scaled  = rounded[32:15];
  end

  // Accumulator: loaded with the dry sample, one echo added per tap read
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      acc <= {{(ACC_W-SAMPLE_W){dry[SAMPLE_W-1]}}, dry};
    end else if (ctrl.add) begin
      acc <= acc + {{(ACC_W-18){scaled[17]}}, scaled};
    end
  end

  // Saturate the full-width sum
  always_comb begin
    if (acc > ACC_W'(32767)) begin
      result = 16'sh7fff;
    end else if (acc < -ACC_W'(32768)) begin
      result = -16'sh8000;
    end else begin
      result = acc[SAMPLE_W-1:0];
    end
  end

endmodule

@@ tb/tb_stereo_multitap_echo.sv @@
module tb_stereo_multitap_echo;
  timeunit 1ns;
  timeprecision 1ps;

  import sme_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD = 300;
  localparam int TAIL_CYCLES = 16;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 60;
  // index 3 lies outside the register map and must be ignored
  localparam logic [1:0] CFG_SPARE_IDX = 2'd3;

  // Scoreboard: mirrors the echo datapath and holds the expected output pairs
  class echo_checker;
    logic [15:0] spacing;
    logic [15:0] gain_set;
    logic [2:0]  tap_set;
    logic [31:0] pair_mem [int];
    int unsigned wr_ptr;
    int unsigned fill;
    logic [31:0] expected_pairs [$];
    int checked;
    int errors;
    int echo_terms;

    function new();
      spacing = TAP_SPACING_RST;
      gain_set = ECHO_GAIN_RST;
      tap_set = TAP_COUNT_RST;
      wr_ptr = 0;
      fill = 0;
      checked = 0;
      errors = 0;
      echo_terms = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_TAP_SPACING: spacing = val;
        CFG_ECHO_GAIN:   gain_set = val;
        CFG_TAP_COUNT:   tap_set = val[2:0];
        default: ;
      endcase
    endfunction

    // Q1.15 product, ties rounded towards plus infinity
    function int scale(int s, int unsigned g);
      longint p;
      p = longint'(s) * longint'(g) + 64'sd16384;
      return int'(p >>> 15);
    endfunction

    function logic [15:0] clip(int v);
      if (v > 32767) return 16'h7fff;
      if (v < -32768) return 16'h8000;
      return v[15:0];
    endfunction

    function int pending();
      return expected_pairs.size();
    endfunction

    // Accepted input transaction: work out the output pair it produces
    function void take_pair(logic [15:0] l, logic [15:0] r, bit byp);
      int acc_l;
      int acc_r;
      int unsigned g;
      int unsigned gmax;
      int unsigned n;
      longint back;
      longint addr;
      logic [31:0] w;
      if (byp) begin
        fill = 0;
        expected_pairs.push_back({r, l});
        return;
      end
      gmax = (gain_set > Q_ONE) ? 32'(Q_ONE) : 32'(gain_set);
      n = (tap_set > MAX_TAPS_DEF) ? 32'(MAX_TAPS_DEF) : 32'(tap_set);
      g = 32'(Q_ONE);
      acc_l = int'($signed(l));
      acc_r = int'($signed(r));
      for (int j = 0; j < n; j++) begin
        back = longint'(spacing) * j + 1;
        // a tap only counts once the history reaches past it
        if (longint'(fill) > back) begin
          addr = longint'(wr_ptr) + DELAY_DEPTH_DEF - back;
          if (addr >= DELAY_DEPTH_DEF) addr -= DELAY_DEPTH_DEF;
          w = pair_mem[int'(addr)];
          acc_l += scale(int'($signed(w[15:0])), g);
          acc_r += scale(int'($signed(w[31:16])), g);
          echo_terms++;
        end
        g = (g * gmax + 16384) >> 15;
      end
      pair_mem[wr_ptr] = {r, l};
      wr_ptr = (wr_ptr + 1) % DELAY_DEPTH_DEF;
      if (fill < DELAY_DEPTH_DEF) fill++;
      expected_pairs.push_back({clip(acc_r), clip(acc_l)});
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("[%0t] MISMATCH %s: got %h, expected %h", $time, what, got, want);
      errors++;
    endtask

    // Accepted output transaction: compare with the oldest expected pair
    task check_pair(logic [31:0] got);
      logic [31:0] want;
      if (expected_pairs.size() == 0) begin
        report("result with none outstanding", got, 32'h0);
        return;
      end
      want = expected_pairs.pop_front();
      checked++;
      if (got[15:0] !== want[15:0]) report("left_out", {16'h0, got[15:0]}, {16'h0, want[15:0]});
      if (got[31:16] !== want[31:16]) begin
        report("right_out", {16'h0, got[31:16]}, {16'h0, want[31:16]});
      end
    endtask

    task finish_check();
      if (expected_pairs.size() != 0) report("results never delivered", expected_pairs.size(), 0);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [31:0] s_tdata = '0;   // [15:0] left_in, [31:16] right_in
  logic s_tuser = 1'b0;        // [0] bypass
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;        // [15:0] left_out, [31:16] right_out
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  echo_checker chk;
  int tx_max = 15;
  int rx_max = 15;
  bit rx_hold_req = 1'b0;
  int cycle_count = 0;
  int items_sent = 0;
  int bypass_sent = 0;
  int settings_used = 0;

  stereo_multitap_echo #(
    .DELAY_DEPTH(DELAY_DEPTH_DEF),
    .MAX_TAPS(MAX_TAPS_DEF)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Run-time guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Output monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready) chk.check_pair(m_tdata);
  end

  // Receiver: random stall per transaction, plus one long hold-off on request
  initial begin
    int stall;
    wait (rst == 1'b0);
    forever begin
      if (rx_hold_req) begin
        @(negedge clk) m_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        rx_hold_req = 1'b0;
      end
      stall = $urandom_range(0, rx_max);
      if (stall > 0) begin
        @(negedge clk) m_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) m_tready <= 1'b1;
      @(posedge clk);
      while (m_tvalid !== 1'b1) @(posedge clk);
    end
  end

  function automatic logic [15:0] pick_sample();
    int v;
    case ($urandom_range(0, 7))
      0: v = 32767;
      1: v = -32768;
      2: v = int'($urandom_range(0, 64)) - 32;
      default: v = $urandom;
    endcase
    return v[15:0];
  endfunction

  task automatic send_pair(logic [15:0] l, logic [15:0] r, bit byp, int gap);
    if (gap > 0) begin
      @(negedge clk) s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {r, l};
    s_tuser <= byp;
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    chk.take_pair(l, r, byp);
    items_sent++;
    if (byp) bypass_sent++;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (chk.pending() != 0) @(posedge clk);
  endtask

  task automatic end_batch();
    @(negedge clk) s_tvalid <= 1'b0;
    wait_drained();
  endtask

  // Register write, only issued while the block is idle
  task automatic set_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    chk.write_reg(idx, val);
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  task automatic random_settings(int p);
    logic [15:0] sp;
    logic [15:0] gn;
    logic [12:0] junk;
    logic [2:0] tc;
    case ($urandom_range(0, 9))
      0: sp = 16'd0;
      1: sp = 16'hffff;
      2: sp = 16'd2205;
      3: sp = 16'd44100;
      default: sp = 16'($urandom_range(1, 24));
    endcase
    case ($urandom_range(0, 5))
      0: gn = 16'd0;
      1: gn = Q_ONE;
      2: gn = 16'hffff;
      3: gn = 16'($urandom);
      default: gn = 16'($urandom_range(8192, 32768));
    endcase
    tc = 3'($urandom_range(0, 7));
    // pin a couple of phases to the extremes
    if (p == 0) begin
      sp = 16'd1;
      gn = Q_ONE;
      tc = 3'd5;
    end else if (p == 1) begin
      sp = 16'hffff;
      gn = 16'd0;
      tc = 3'd0;
    end
    junk = 13'($urandom);
    set_reg(CFG_TAP_SPACING, sp);
    set_reg(CFG_ECHO_GAIN, gn);
    set_reg(CFG_TAP_COUNT, {junk, tc});
    settings_used++;
  endtask

  task automatic run_phase(int count, int byp_odds);
    for (int i = 0; i < count; i++) begin
      // now and then the sender waits for every outstanding result
      if ($urandom_range(0, 39) == 0) begin
        @(negedge clk) s_tvalid <= 1'b0;
        wait_drained();
      end
      send_pair(pick_sample(), pick_sample(), $urandom_range(0, byp_odds - 1) == 0,
                $urandom_range(0, tx_max));
    end
    end_batch();
  endtask

  // Stimulus
  initial begin
    chk = new();
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // reset settings: only the one-back tap can be reached
    settings_used++;
    send_pair(16'h7fff, 16'h8000, 1'b0, $urandom_range(0, 15));
    send_pair(16'h7fff, 16'h8000, 1'b0, $urandom_range(0, 15));
    send_pair(16'h0000, 16'hffff, 1'b0, $urandom_range(0, 15));
    send_pair(16'h1234, 16'hedcb, 1'b0, $urandom_range(0, 15));
    end_batch();

    // zero spacing, gain above one and tap count above the maximum
    set_reg(CFG_TAP_SPACING, 16'd0);
    set_reg(CFG_ECHO_GAIN, 16'hffff);
    set_reg(CFG_TAP_COUNT, 16'd7);
    settings_used++;
    repeat (3) send_pair(16'h7fff, 16'h7fff, 1'b0, $urandom_range(0, 15));
    repeat (3) send_pair(16'h8000, 16'h8000, 1'b0, $urandom_range(0, 15));
    send_pair(16'h7fff, 16'h8000, 1'b1, $urandom_range(0, 15));
    send_pair(16'h8000, 16'h7fff, 1'b0, $urandom_range(0, 15));
    send_pair(16'h0001, 16'hffff, 1'b0, $urandom_range(0, 15));
    end_batch();

    // half gain on tight taps: rounding ties on small samples, spare index ignored
    set_reg(CFG_TAP_SPACING, 16'd1);
    set_reg(CFG_ECHO_GAIN, 16'd16384);
    set_reg(CFG_TAP_COUNT, 16'd5);
    set_reg(CFG_SPARE_IDX, 16'hffff);
    settings_used++;
    send_pair(16'h0001, 16'hffff, 1'b0, $urandom_range(0, 15));
    send_pair(16'hffff, 16'h0001, 1'b0, $urandom_range(0, 15));
    send_pair(16'h0001, 16'hffff, 1'b0, $urandom_range(0, 15));
    send_pair(16'hffff, 16'h0001, 1'b0, $urandom_range(0, 15));
    send_pair(16'h0003, 16'hfffd, 1'b0, $urandom_range(0, 15));
    send_pair(16'h0000, 16'h0000, 1'b0, $urandom_range(0, 15));
    send_pair(16'h3039, 16'hcfc7, 1'b0, $urandom_range(0, 15));
    send_pair(16'h0000, 16'h0000, 1'b1, $urandom_range(0, 15));
    send_pair(16'h7fff, 16'h8000, 1'b0, $urandom_range(0, 15));
    send_pair(16'h0005, 16'hfffb, 1'b0, $urandom_range(0, 15));
    end_batch();

    // random phases, each under fresh register settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_settings(p);
      tx_max = (p % 3 == 1 || p == 3) ? 0 : 15;
      rx_max = (p % 3 == 1 || p % 4 == 2) ? 0 : 15;
      // back-pressure phase: receiver holds off while the sender keeps pushing
      if (p == 3) rx_hold_req = 1'b1;
      run_phase(PHASE_ITEMS, (p == 5) ? 6 : 40);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    chk.finish_check();

    $display("Covered %0d input pairs (%0d bypass) across %0d register settings",
             items_sent, bypass_sent, settings_used);
    $display("Compared %0d output pairs, %0d echo terms summed, %0d mismatches",
             chk.checked, chk.echo_terms, chk.errors);
    if (chk.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
